// ----- rtl/lcs_pkg.sv -----
// Shared types and constants for the LED cube BCM layer scanner.
package lcs_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic       opcode;
    logic [2:0] col;
    logic [2:0] row;
    logic [2:0] plane;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } in_t;

  typedef struct packed {
    logic       red_serial;
    logic       green_serial;
    logic       blue_serial;
    logic [2:0] lit_layer;
    logic [2:0] weight_bit;
    logic       latch_last;
  } out_t;

  // Classified command passed from the front end to the scan engine.
  typedef struct packed {
    logic       is_tick;
    logic [2:0] col;
    logic [2:0] row;
    logic [2:0] plane;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic scanning;
  } eng_status_t;

endpackage

// ----- rtl/lcs_front.sv -----
// Front end: accepts input beats, drops out-of-range writes, builds commands.
module lcs_front #(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 8,
  parameter int LAYERS  = 8
) (
  input  logic          in_valid,
  input  lcs_pkg::in_t  in_data,
  output logic          in_stall,
  input  logic          q_full,
  input  logic          clearing,
  output logic          q_push,
  output lcs_pkg::cmd_t q_cmd
);

  logic is_tick;
  logic in_range;

  assign is_tick  = (in_data.opcode == lcs_pkg::OP_TICK);
  assign in_range = (int'(in_data.col) < COLUMNS) && (int'(in_data.row) < ROWS) &&
                    (int'(in_data.plane) < LAYERS);

  // No beats taken during the post-reset clear or with the queue full.
  assign in_stall = q_full || clearing;

  assign q_push = in_valid && !in_stall && (is_tick || in_range);

  always_comb begin
    q_cmd.is_tick = is_tick;
    q_cmd.col     = in_data.col;
    q_cmd.row     = in_data.row;
    q_cmd.plane   = in_data.plane;
    q_cmd.red     = in_data.red_level;
    q_cmd.green   = in_data.green_level;
    q_cmd.blue    = in_data.blue_level;
  end

endmodule

// ----- rtl/lcs_cmd_fifo.sv -----
// Short command queue between the front end and the scan engine.
module lcs_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output lcs_pkg::cmd_t head
);

  localparam int DEPTH = lcs_pkg::CMD_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  lcs_pkg::cmd_t q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == NW'(DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/lcs_scan_engine.sv -----
// Back end: voxel store, clear sweep, layer scan sequencer, BCM state, output queue.
module lcs_scan_engine #(
  parameter int COLUMNS    = 8,
  parameter int ROWS       = 8,
  parameter int LAYERS     = 8,
  parameter int COLOR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  lcs_pkg::cmd_t        cmd,
  output logic                 cmd_pop,
  output lcs_pkg::eng_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcs_pkg::out_t        out_data
);

  localparam int VOXELS = COLUMNS * ROWS * LAYERS;
  localparam int AW     = $clog2(VOXELS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int LAW    = $clog2(LAYERS);
  localparam int BPW    = $clog2(COLOR_BITS);
  localparam int TW     = COLOR_BITS;
  localparam int DW     = 3 * COLOR_BITS;

  // voxel store, COLOR_BITS per channel (higher level bits never shown)
  logic [DW-1:0] mem [VOXELS];
  logic [DW-1:0] rd_q_r;

  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          scan_r, scan_nxt;
  logic [RW-1:0] y_r, y_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [LAW-1:0] layer_r, layer_nxt;
  logic [BPW-1:0] bp_r, bp_nxt;
  logic [TW-1:0]  tick_r, tick_nxt;
  logic [TW-1:0]  thr_r, thr_nxt;
  logic [TW-1:0]  tick_inc;

  logic           rd_v_r, rd_v_nxt;
  logic [LAW-1:0] md_lay_r;
  logic [BPW-1:0] md_bp_r;
  logic           md_last_r;

  lcs_pkg::out_t oq_r [2];
  logic          owp_r, owp_nxt;
  logic          orp_r, orp_nxt;
  logic [1:0]    ocnt_r, ocnt_nxt;

  logic [CW-1:0] col_sel;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] wr_addr;
  logic          issue;
  logic          last;
  logic          out_pop;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;
  lcs_pkg::out_t push_item;

  assign status.clearing = clr_r;
  assign status.scanning = scan_r;

  // odd rows run their columns reversed
  assign col_sel   = y_r[0] ? (CW'(COLUMNS - 1) - s_r) : s_r;
  assign scan_addr = AW'((int'(layer_r) * ROWS + int'(y_r)) * COLUMNS + int'(col_sel));
  assign wr_addr   = AW'((int'(cmd.plane) * ROWS + int'(cmd.row)) * COLUMNS + int'(cmd.col));

  assign out_valid = (ocnt_r != 2'd0);
  assign out_data  = oq_r[orp_r];
  assign out_pop   = out_valid && !out_stall;

  // credit check: queued + in-flight reads must fit the two output slots
  assign issue = scan_r && ((3'(ocnt_r) + 3'(rd_v_r)) < (3'd2 + 3'(out_pop)));
  assign last  = (y_r == '0) && (s_r == '0);

  assign cmd_pop = cmd_valid && !scan_r && !clr_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr;
    mem_wd = {cmd.red[COLOR_BITS-1:0], cmd.green[COLOR_BITS-1:0], cmd.blue[COLOR_BITS-1:0]};
    if (clr_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (cmd_pop && !cmd.is_tick) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_q_r <= mem[scan_addr];
    end
  end

  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    scan_nxt    = scan_r;
    y_nxt       = y_r;
    s_nxt       = s_r;
    layer_nxt   = layer_r;
    bp_nxt      = bp_r;
    tick_nxt    = tick_r;
    thr_nxt     = thr_r;
    rd_v_nxt    = issue;

    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(VOXELS - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    if (cmd_pop && cmd.is_tick) begin
      scan_nxt = 1'b1;
      y_nxt    = RW'(ROWS - 1);
      s_nxt    = CW'(COLUMNS - 1);
    end

    if (issue) begin
      if (s_r == '0) begin
        s_nxt = CW'(COLUMNS - 1);
        y_nxt = y_r - 1'b1;
      end else begin
        s_nxt = s_r - 1'b1;
      end
      if (last) begin
        scan_nxt  = 1'b0;
        layer_nxt = (layer_r == LAW'(LAYERS - 1)) ? '0 : layer_r + 1'b1;
        tick_nxt  = tick_inc;
        if (tick_inc == thr_r) begin
          if (bp_r == BPW'(COLOR_BITS - 1)) begin
            bp_nxt   = '0;
            tick_nxt = '0;
            thr_nxt  = TW'(1);
          end else begin
            bp_nxt  = bp_r + 1'b1;
            thr_nxt = thr_r << 1;
          end
        end
      end
    end
  end

  always_comb begin
    push_item.red_serial   = rd_q_r[2*COLOR_BITS + int'(md_bp_r)];
    push_item.green_serial = rd_q_r[COLOR_BITS + int'(md_bp_r)];
    push_item.blue_serial  = rd_q_r[int'(md_bp_r)];
    push_item.lit_layer    = 3'(md_lay_r);
    push_item.weight_bit   = 3'(md_bp_r);
    push_item.latch_last   = md_last_r;

    owp_nxt  = rd_v_r ? ~owp_r : owp_r;
    orp_nxt  = out_pop ? ~orp_r : orp_r;
    ocnt_nxt = ocnt_r + 2'(rd_v_r) - 2'(out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      scan_r    <= 1'b0;
      y_r       <= '0;
      s_r       <= '0;
      layer_r   <= '0;
      bp_r      <= '0;
      tick_r    <= '0;
      thr_r     <= TW'(1);
      rd_v_r    <= 1'b0;
      owp_r     <= 1'b0;
      orp_r     <= 1'b0;
      ocnt_r    <= 2'd0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      scan_r    <= scan_nxt;
      y_r       <= y_nxt;
      s_r       <= s_nxt;
      layer_r   <= layer_nxt;
      bp_r      <= bp_nxt;
      tick_r    <= tick_nxt;
      thr_r     <= thr_nxt;
      rd_v_r    <= rd_v_nxt;
      owp_r     <= owp_nxt;
      orp_r     <= orp_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  // read metadata travels with the registered memory data
  always_ff @(posedge clk) begin
    if (issue) begin
      md_lay_r  <= layer_r;
      md_bp_r   <= bp_r;
      md_last_r <= last;
    end
    if (rd_v_r) begin
      oq_r[owp_r] <= push_item;
    end
  end

endmodule

// ----- rtl/led_cube_bcm_layer_scanner_core.sv -----
// Top level of the LED cube BCM layer scanner: front end, command queue, scan engine.
// Path: an accepted refresh tick goes through the command queue, the scan start, the
//   registered store read and the output queue; the beats of a layer then follow back to back unless out_stall holds.
// Busy: a tick holds the store's read port until all COLUMNS*ROWS beats of its layer
//   are read; the scan engine takes no command, voxel write included, while it scans.
// Reset: synchronous, active low; then a clear sweep writes all COLUMNS*ROWS*LAYERS
//   voxels dark, one per cycle (512 at default), with in_stall held high throughout.
module led_cube_bcm_layer_scanner_core #(
  parameter int COLUMNS    = 8,
  parameter int ROWS       = 8,
  parameter int LAYERS     = 8,
  parameter int COLOR_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lcs_pkg::out_t out_data
);

  // Front end classifies each beat: a tick always goes to the queue, a write
  // goes only when its column, row and plane fall inside the cube.
  logic                 q_push;
  lcs_pkg::cmd_t        q_cmd;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  lcs_pkg::cmd_t        q_head;
  lcs_pkg::eng_status_t eng_st;

  lcs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .LAYERS  (LAYERS)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .clearing (eng_st.clearing),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Queue lets the front keep taking beats while a layer is being shifted.
  lcs_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Scan engine: commands run strictly in order, so a write never disturbs a
  // refresh that came before it. Shift order is rows descending, columns
  // descending, odd rows reversed; the last beat of a layer carries the latch.
  lcs_scan_engine #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .LAYERS     (LAYERS),
    .COLOR_BITS (COLOR_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .status    (eng_st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // No result can exist before the store has been swept dark.
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    eng_st.clearing |-> !out_valid)
    else $error("result beat during clear sweep");

  // Nothing is queued while the clear sweep runs.
  a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    eng_st.clearing |-> !q_valid)
    else $error("command queued during clear sweep");

  // A scan starts only from a popped refresh command.
  a_scan_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(eng_st.scanning) |-> $past(q_pop && q_head.is_tick))
    else $error("scan started without a refresh command");

endmodule
